FILE: hdl/qrs_pkg.sv
// Package with the shared constants of the quadratic root solver.
package qrs_pkg;

  // Width of every root part on the result ports (signed).
  localparam int OUT_WIDTH = 34;

  // Default coefficient width and number of fraction bits.
  localparam int DEF_COEF_WIDTH = 16;
  localparam int DEF_FRAC_BITS  = 16;

endpackage

FILE: hdl/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: coefficients in, Q18.16 roots out.
//
// The unit takes one item (coefficients a, b, c) in every clock cycle and never
// raises busy. Each item gives exactly one result, marked by done for a single
// cycle. An item passes through the coefficient, product and discriminant
// registers, then the square root pipeline, which resolves one root bit per
// stage, the numerator and divider input registers, the divider pipeline,
// which resolves one quotient bit per stage, and the sign and output registers.
// Results are in the order of the items and the receiver must take each one
// as it appears. When a is zero, zero_leading is set and all root parts
// read as zero.
module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = qrs_pkg::DEF_COEF_WIDTH,
  parameter int FRAC_BITS  = qrs_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COEF_WIDTH-1:0]        coef_a,
  input  logic signed [COEF_WIDTH-1:0]        coef_b,
  input  logic signed [COEF_WIDTH-1:0]        coef_c,
  output logic                                done,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] root1_re,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] root1_im,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] root2_re,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0] root2_im,
  output logic                                complex_pair,
  output logic                                zero_leading
);

  localparam int W     = COEF_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int OW    = qrs_pkg::OUT_WIDTH;
  localparam int PW    = 2 * W;
  localparam int DW    = 2 * W + 3;
  localparam int MAGW  = 2 * W + 1;
  localparam int ROOTW = W + F + 1;
  localparam int NSW   = W + F + 3;
  localparam int NW    = W + F + 2;
  localparam int DVW   = W + 1;
  localparam int XW    = ((NW > OW) ? NW : OW) + 1;
  localparam int SQSB  = 2 * W + 1;

  localparam logic [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};
  localparam logic [XW-1:0] POS_LIM = XW'(OUT_MAX);
  localparam logic [XW-1:0] NEG_LIM = XW'(OUT_MIN);

  // Apply the quotient sign and clamp to the signed output range.
  function automatic logic [OW-1:0] sat_q(input logic [NW-1:0] q, input logic neg);
    logic [XW-1:0] qx;
    logic [XW-1:0] nq;
    qx = XW'(q);
    nq = XW'(0) - qx;
    if (neg) begin
      sat_q = (qx > NEG_LIM) ? OUT_MIN : nq[OW-1:0];
    end else begin
      sat_q = (qx > POS_LIM) ? OUT_MAX : qx[OW-1:0];
    end
  endfunction

  // The unit never holds items off.
  assign busy = 1'b0;

  // Stage 1: capture the coefficients.
  logic                v1;
  logic signed [W-1:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    a1 <= coef_a;
    b1 <= coef_b;
    c1 <= coef_c;
  end

  // Stage 2: the two products of the discriminant.
  logic                 v2;
  logic signed [W-1:0]  a2, b2;
  logic signed [PW-1:0] bb2, ac2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    a2  <= a1;
    b2  <= b1;
    bb2 <= PW'(b1) * PW'(b1);
    ac2 <= PW'(a1) * PW'(c1);
  end

  // Stage 3: discriminant, its sign and its magnitude.
  logic signed [DW-1:0] disc;
  logic [DW-1:0]        disc_abs;
  logic                 v3;
  logic signed [W-1:0]  a3, b3;
  logic                 neg3;
  logic [MAGW-1:0]      mag3;

  always_comb begin
    disc     = DW'(bb2) - (DW'(ac2) <<< 2);
    disc_abs = disc[DW-1] ? (DW'(0) - disc) : disc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    a3   <= a2;
    b3   <= b2;
    neg3 <= disc[DW-1];
    mag3 <= disc_abs[MAGW-1:0];
  end

  // Square root of the scaled discriminant magnitude.
  logic             sq_valid;
  logic [ROOTW-1:0] sq_root;
  logic [SQSB-1:0]  sq_sb;

  qrs_sqrt #(
    .MAGW  (MAGW),
    .FRAC  (F),
    .ROOTW (ROOTW),
    .SBW   (SQSB)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_mag    (mag3),
    .in_sb     ({a3, b3, neg3}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  // Stage 4: form the two numerators for the real or the complex case.
  logic signed [W-1:0]   sa, sb_b;
  logic                  sneg;
  logic signed [NSW-1:0] nb, sx;
  logic                  v4;
  logic signed [W-1:0]   a4;
  logic                  cplx4;
  logic signed [NSW-1:0] n1_4, n2_4;

  always_comb begin
    sa   = sq_sb[SQSB-1 -: W];
    sb_b = sq_sb[W:1];
    sneg = sq_sb[0];
    nb   = NSW'(0) - (NSW'(sb_b) <<< F);
    sx   = NSW'({2'b00, sq_root});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    a4    <= sa;
    cplx4 <= sneg;
    n1_4  <= sneg ? nb : (nb + sx);
    n2_4  <= sneg ? sx : (nb - sx);
  end

  // Stage 5: magnitudes and quotient signs for the divider.
  logic signed [W+1:0]   den;
  logic [W+1:0]          den_abs;
  logic [NSW-1:0]        m1_abs, m2_abs;
  logic                  v5;
  logic [NW-1:0]         m1_5, m2_5;
  logic [DVW-1:0]        d5;
  logic [3:0]            flags5;

  always_comb begin
    den     = (W+2)'(a4) <<< 1;
    den_abs = den[W+1] ? ((W+2)'(0) - den) : den;
    m1_abs  = n1_4[NSW-1] ? (NSW'(0) - n1_4) : n1_4;
    m2_abs  = n2_4[NSW-1] ? (NSW'(0) - n2_4) : n2_4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  // Flags order: sign of quotient one, sign of quotient two, complex, a zero.
  always_ff @(posedge clk) begin
    m1_5   <= m1_abs[NW-1:0];
    m2_5   <= m2_abs[NW-1:0];
    d5     <= den_abs[DVW-1:0];
    flags5 <= {n1_4[NSW-1] ^ a4[W-1], n2_4[NSW-1] ^ a4[W-1], cplx4, (a4 == '0)};
  end

  // Both divisions run side by side through one divider pipeline.
  logic          dq_valid;
  logic [NW-1:0] dq1, dq2;
  logic [3:0]    dq_flags;

  qrs_div2 #(
    .NW  (NW),
    .DVW (DVW),
    .SBW (4)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_n1     (m1_5),
    .in_n2     (m2_5),
    .in_d      (d5),
    .in_sb     (flags5),
    .out_valid (dq_valid),
    .out_q1    (dq1),
    .out_q2    (dq2),
    .out_sb    (dq_flags)
  );

  // Stage 6: signed and clamped quotients.
  logic          v6;
  logic [OW-1:0] q1_6, q2_6;
  logic          cplx6, zero6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    q1_6  <= sat_q(dq1, dq_flags[3]);
    q2_6  <= sat_q(dq2, dq_flags[2]);
    cplx6 <= dq_flags[1];
    zero6 <= dq_flags[0];
  end

  // Stage 7: arrange the root parts for the result.
  logic [OW-1:0] q2_neg;

  always_comb begin
    q2_neg = (q2_6 == OUT_MIN) ? OUT_MAX : (OW'(0) - q2_6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    zero_leading <= zero6;
    if (zero6) begin
      root1_re     <= '0;
      root1_im     <= '0;
      root2_re     <= '0;
      root2_im     <= '0;
      complex_pair <= 1'b0;
    end else if (cplx6) begin
      root1_re     <= q1_6;
      root1_im     <= q2_6;
      root2_re     <= q1_6;
      root2_im     <= q2_neg;
      complex_pair <= 1'b1;
    end else begin
      root1_re     <= q1_6;
      root1_im     <= '0;
      root2_re     <= q2_6;
      root2_im     <= '0;
      complex_pair <= 1'b0;
    end
  end

endmodule

FILE: hdl/qrs_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
module qrs_sqrt #(
  parameter int MAGW  = 33,
  parameter int FRAC  = 16,
  parameter int ROOTW = 33,
  parameter int SBW   = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [MAGW-1:0]  in_mag,
  input  logic [SBW-1:0]   in_sb,
  output logic             out_valid,
  output logic [ROOTW-1:0] out_root,
  output logic [SBW-1:0]   out_sb
);

  localparam int RADW = 2 * ROOTW;
  localparam int RW   = ROOTW + 3;

  logic             vld  [0:ROOTW];
  logic [RW-1:0]    rem  [0:ROOTW];
  logic [ROOTW-1:0] root [0:ROOTW];
  logic [RADW-1:0]  rad  [0:ROOTW];
  logic [SBW-1:0]   sb   [0:ROOTW];

  // Stage zero is the incoming item with the radicand scaled by 2^(2*FRAC).
  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = RADW'(in_mag) << (2 * FRAC);
  assign sb[0]   = in_sb;

  for (genvar k = 0; k < ROOTW; k++) begin : g_stage
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    logic          ge;

    // Bring down the next pair of radicand bits and try the next root bit.
    always_comb begin
      cur   = {rem[k][RW-3:0], rad[k][RADW-1 -: 2]};
      trial = RW'({root[k], 2'b01});
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? (cur - trial) : cur;
      root[k+1] <= {root[k][ROOTW-2:0], ge};
      rad[k+1]  <= rad[k] << 2;
      sb[k+1]   <= sb[k];
    end
  end

  assign out_valid = vld[ROOTW];
  assign out_root  = root[ROOTW];
  assign out_sb    = sb[ROOTW];

endmodule

FILE: hdl/qrs_div2.sv
// Pipelined restoring divider with two lanes sharing one divisor.
module qrs_div2 #(
  parameter int NW  = 34,
  parameter int DVW = 17,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_n1,
  input  logic [NW-1:0]  in_n2,
  input  logic [DVW-1:0] in_d,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [NW-1:0]  out_q1,
  output logic [NW-1:0]  out_q2,
  output logic [SBW-1:0] out_sb
);

  logic           vld [0:NW];
  logic [NW-1:0]  n1  [0:NW];
  logic [NW-1:0]  n2  [0:NW];
  logic [DVW-1:0] r1  [0:NW];
  logic [DVW-1:0] r2  [0:NW];
  logic [NW-1:0]  q1  [0:NW];
  logic [NW-1:0]  q2  [0:NW];
  logic [DVW-1:0] dv  [0:NW];
  logic [SBW-1:0] sb  [0:NW];

  assign vld[0] = in_valid;
  assign n1[0]  = in_n1;
  assign n2[0]  = in_n2;
  assign r1[0]  = '0;
  assign r2[0]  = '0;
  assign q1[0]  = '0;
  assign q2[0]  = '0;
  assign dv[0]  = in_d;
  assign sb[0]  = in_sb;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DVW:0] t1;
    logic [DVW:0] t2;
    logic         ge1;
    logic         ge2;

    // Shift in the next dividend bit and subtract the divisor where it fits.
    always_comb begin
      t1  = {r1[k], n1[k][NW-1]};
      t2  = {r2[k], n2[k][NW-1]};
      ge1 = (t1 >= (DVW+1)'(dv[k]));
      ge2 = (t2 >= (DVW+1)'(dv[k]));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      r1[k+1] <= ge1 ? DVW'(t1 - (DVW+1)'(dv[k])) : t1[DVW-1:0];
      r2[k+1] <= ge2 ? DVW'(t2 - (DVW+1)'(dv[k])) : t2[DVW-1:0];
      q1[k+1] <= {q1[k][NW-2:0], ge1};
      q2[k+1] <= {q2[k][NW-2:0], ge2};
      n1[k+1] <= n1[k] << 1;
      n2[k+1] <= n2[k] << 1;
      dv[k+1] <= dv[k];
      sb[k+1] <= sb[k];
    end
  end

  assign out_valid = vld[NW];
  assign out_q1    = q1[NW];
  assign out_q2    = q2[NW];
  assign out_sb    = sb[NW];

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the quadratic root solver unit.
module tb;

  localparam int CW = qrs_pkg::DEF_COEF_WIDTH;
  localparam int FB = qrs_pkg::DEF_FRAC_BITS;
  localparam int OW = qrs_pkg::OUT_WIDTH;
  localparam int LATENCY = 2 * CW + 2 * FB + 10;

  typedef struct packed {
    logic signed [OW-1:0] r1re;
    logic signed [OW-1:0] r1im;
    logic signed [OW-1:0] r2re;
    logic signed [OW-1:0] r2im;
    logic                 cplx;
    logic                 zlead;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] coef_a = '0;
  logic signed [CW-1:0] coef_b = '0;
  logic signed [CW-1:0] coef_c = '0;
  logic done;
  logic signed [OW-1:0] root1_re, root1_im, root2_re, root2_im;
  logic complex_pair, zero_leading;

  roots_t pending_roots[$];
  int mismatches = 0;
  int send_idle_pct = 0;

  quadratic_root_solver_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .done(done), .root1_re(root1_re), .root1_im(root1_im),
    .root2_re(root2_re), .root2_im(root2_im),
    .complex_pair(complex_pair), .zero_leading(zero_leading)
  );

  always #1 clk = ~clk;

  // Square root by digit recurrence: floor(sqrt(mag * 2^(2*FB))).
  function automatic logic [63:0] scaled_sqrt(input logic [63:0] mag);
    logic [127:0] rad;
    logic [127:0] rem;
    logic [127:0] trial;
    logic [63:0] root;
    rad = {64'd0, mag} << (2 * FB);
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
      trial = ({64'd0, root} << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Quotient truncated toward zero, saturated to the output range.
  function automatic logic signed [OW-1:0] trunc_div(input longint n, input longint d);
    longint q;
    longint omax;
    omax = (longint'(1) <<< (OW - 1)) - 1;
    q = n / d;
    if (q > omax) return omax[OW-1:0];
    if (q < -omax - 1) return OW'(-omax - 1);
    return q[OW-1:0];
  endfunction

  // Expected roots of one item.
  function automatic roots_t solve_roots(input logic signed [CW-1:0] a_in,
                                         input logic signed [CW-1:0] b_in,
                                         input logic signed [CW-1:0] c_in);
    roots_t r;
    longint a, b, c, disc, den, nb, s;
    logic [63:0] mag;
    r = '0;
    a = a_in;
    b = b_in;
    c = c_in;
    if (a == 0) begin
      r.zlead = 1'b1;
    end else begin
      disc = b * b - 4 * a * c;
      den = 2 * a;
      nb = -b * (longint'(1) <<< FB);
      mag = disc < 0 ? -disc : disc;
      s = longint'(scaled_sqrt(mag));
      if (disc >= 0) begin
        r.r1re = trunc_div(nb + s, den);
        r.r2re = trunc_div(nb - s, den);
      end else begin
        r.cplx = 1'b1;
        r.r1re = trunc_div(nb, den);
        r.r2re = r.r1re;
        r.r1im = trunc_div(s, den);
        // The negated imaginary part clamps at the top of the range.
        r.r2im = (r.r1im == {1'b1, {(OW-1){1'b0}}}) ? {1'b0, {(OW-1){1'b1}}}
                                                     : -r.r1im;
      end
    end
    return r;
  endfunction

  // Each result is compared with the oldest expectation.
  always @(posedge clk) begin
    roots_t got, want;
    if (!rst && done) begin
      got = '{root1_re, root1_im, root2_re, root2_im, complex_pair, zero_leading};
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = pending_roots.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Sends one item, idling before it at the current rate.
  task automatic send_item(input logic signed [CW-1:0] a, input logic signed [CW-1:0] b,
                           input logic signed [CW-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_roots.insert(pending_roots.size(), solve_roots(a, b, c));
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // The sender pauses until every expected result has come.
  task automatic drain();
    go_idle();
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  // Field extremes, zero leading coefficient, real and conjugate roots.
  task automatic test_directed();
    logic signed [CW-1:0] ext[5] = '{CW'(-32768), CW'(-1), CW'(0), CW'(1), CW'(32767)};
    send_idle_pct = 0;
    send_item(CW'(0), CW'(5), CW'(7));
    send_item(CW'(0), CW'(-32768), CW'(32767));
    send_item(CW'(1), CW'(0), CW'(-4));
    send_item(CW'(1), CW'(2), CW'(1));
    send_item(CW'(1), CW'(0), CW'(1));
    send_item(CW'(-3), CW'(7), CW'(-9));
    send_item(CW'(2), CW'(-5), CW'(2));
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 3; j++)
        send_item(ext[i], ext[(i + j + 1) % 5], ext[(i + 2 * j) % 5]);
    drain();
  endtask

  // Random coefficients, often small so that real and complex roots both occur.
  task automatic test_random(input int count, input int idle_pct);
    logic signed [CW-1:0] a, b, c;
    send_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      a = CW'($urandom);
      b = CW'($urandom);
      c = CW'($urandom);
      case ($urandom_range(3))
        0: begin
          a = CW'($signed(4'($urandom)));
          b = CW'($signed(8'($urandom)));
          c = CW'($signed(4'($urandom)));
        end
        1: a = $urandom_range(1) ? 16'sd0 : a;
        default: ;
      endcase
      send_item(a, b, c);
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(360, 0);
    test_random(360, 57);
    test_random(360, 57);
    test_random(360, 11);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/qrs_pkg.sv
hdl/qrs_sqrt.sv
hdl/qrs_div2.sv
hdl/quadratic_root_solver_unit.sv
tb/tb.sv
